[src/vfb_pkg.sv]
// Package for the view frame block: beat types and fixed-point constants.
// Used by vfb_sincos and view_frame_from_bearing; depends on nothing.
`default_nettype none

package vfb_pkg;

   localparam int THR_W  = 15;
   localparam int SC_LAT = 15;
   localparam int STEPS  = 6;

   localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
   localparam logic [29:0] Q30_HALF = 30'h2000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [32:0] HALF_LSB_Q30 = 33'h2000_0000;

   localparam int SIN_SHIFT [STEPS] = '{38, 37, 37, 36, 35, 33};
   localparam int COS_SHIFT [STEPS] = '{38, 37, 36, 35, 34, 31};

   localparam logic [31:0] SIN_MAGIC [STEPS] = '{
      32'(((64'd1 << 38) + 64'd155) / 64'd156),
      32'(((64'd1 << 37) + 64'd109) / 64'd110),
      32'(((64'd1 << 37) + 64'd71) / 64'd72),
      32'(((64'd1 << 36) + 64'd41) / 64'd42),
      32'(((64'd1 << 35) + 64'd19) / 64'd20),
      32'(((64'd1 << 33) + 64'd5) / 64'd6)
   };

   localparam logic [31:0] COS_MAGIC [STEPS] = '{
      32'(((64'd1 << 38) + 64'd131) / 64'd132),
      32'(((64'd1 << 37) + 64'd89) / 64'd90),
      32'(((64'd1 << 36) + 64'd55) / 64'd56),
      32'(((64'd1 << 35) + 64'd29) / 64'd30),
      32'(((64'd1 << 34) + 64'd11) / 64'd12),
      32'(((64'd1 << 31) + 64'd1) / 64'd2)
   };

   typedef struct packed {
      logic               op;
      logic [15:0]        azimuth;
      logic signed [15:0] altitude;
   } req_type;

   typedef struct packed {
      logic signed [15:0] row0_col0;
      logic signed [15:0] row0_col1;
      logic signed [15:0] row0_col2;
      logic signed [15:0] row1_col0;
      logic signed [15:0] row1_col1;
      logic signed [15:0] row1_col2;
      logic signed [15:0] row2_col0;
      logic signed [15:0] row2_col1;
      logic signed [15:0] row2_col2;
      logic               overhead;
   } rsp_type;

endpackage

`default_nettype wire

[src/vfb_sincos.sv]
// Pipelined sine and cosine of a 32-bit turn angle, octant folded, Q30 results.
// Depends on vfb_pkg for the series constants and the pipeline length.
`default_nettype none

module vfb_sincos (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        valid_in,
   input  wire logic [31:0] turn,
   input  wire logic        tag_in,
   output logic             valid_out,
   output logic [30:0]      sin_q30,
   output logic [30:0]      cos_q30,
   output logic [1:0]       quad_out,
   output logic             tag_out
);
   import vfb_pkg::*;

   logic [SC_LAT-1:0] vld_ff;
   logic [SC_LAT-1:0] fold_ff;
   logic [SC_LAT-1:0] tag_ff;
   logic [1:0]        quad_ff [SC_LAT];
   logic [29:0]       x_ff  [0:13];
   logic [29:0]       x2_ff [1:11];
   logic [29:0]       ps_ff [STEPS];
   logic [29:0]       pc_ff [STEPS];
   logic [30:0]       ts_ff [STEPS];
   logic [30:0]       tc_ff [STEPS];
   logic [30:0]       sin_ff;
   logic [30:0]       cos_ff;

   logic [29:0] r_in;
   logic        fold_in;
   logic [30:0] rr_in;
   logic [62:0] xprod_in;
   logic [29:0] x_in;

   always_comb begin
      r_in     = turn[29:0];
      fold_in  = r_in > Q30_HALF;
      rr_in    = fold_in ? (Q30_ONE - {1'b0, r_in}) : {1'b0, r_in};
      xprod_in = 63'(rr_in) * 63'(HALF_PI_Q30) + 63'(HALF_LSB_Q30);
      x_in     = xprod_in[59:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SC_LAT-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      fold_ff    <= {fold_ff[SC_LAT-2:0], fold_in};
      tag_ff     <= {tag_ff[SC_LAT-2:0], tag_in};
      quad_ff[0] <= turn[31:30];
      for (int k = 1; k < SC_LAT; k++) begin
         quad_ff[k] <= quad_ff[k-1];
      end
      x_ff[0] <= x_in;
      for (int k = 1; k < 14; k++) begin
         x_ff[k] <= x_ff[k-1];
      end
      x2_ff[1] <= 30'((60'(x_ff[0]) * 60'(x_ff[0])) >> 30);
      for (int k = 2; k < 12; k++) begin
         x2_ff[k] <= x2_ff[k-1];
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [30:0] s_prev;
      logic [30:0] c_prev;
      if (i == 0) begin : g_first
         assign s_prev = Q30_ONE;
         assign c_prev = Q30_ONE;
      end else begin : g_next
         assign s_prev = ts_ff[i-1];
         assign c_prev = tc_ff[i-1];
      end
      always_ff @(posedge clock) begin
         ps_ff[i] <= 30'((61'(x2_ff[2*i+1]) * 61'(s_prev)) >> 30);
         pc_ff[i] <= 30'((61'(x2_ff[2*i+1]) * 61'(c_prev)) >> 30);
         ts_ff[i] <= Q30_ONE - 31'((62'(ps_ff[i]) * 62'(SIN_MAGIC[i])) >> SIN_SHIFT[i]);
         tc_ff[i] <= Q30_ONE - 31'((62'(pc_ff[i]) * 62'(COS_MAGIC[i])) >> COS_SHIFT[i]);
      end
   end

   always_ff @(posedge clock) begin
      sin_ff <= 31'((61'(x_ff[13]) * 61'(ts_ff[STEPS-1])) >> 30);
      cos_ff <= tc_ff[STEPS-1];
   end

   assign valid_out = vld_ff[SC_LAT-1];
   assign sin_q30   = fold_ff[SC_LAT-1] ? cos_ff : sin_ff;
   assign cos_q30   = fold_ff[SC_LAT-1] ? sin_ff : cos_ff;
   assign quad_out  = quad_ff[SC_LAT-1];
   assign tag_out   = tag_ff[SC_LAT-1];

endmodule

`default_nettype wire

[src/view_frame_from_bearing.sv]
// Top level of the view frame block: bearing and altitude in, 3x3 rotation out.
// Depends on vfb_pkg and vfb_sincos.
`default_nettype none

// Usage: drive req_data and raise start for one cycle per beat. busy is always
// low, so a new beat is taken at every edge where start is high. Each beat
// runs through two sine/cosine pipelines, one per angle, and then through four
// stages that apply the quadrant signs, form the eye and right rows, form the
// up row and round the output. The result beat appears on rsp_data with
// rsp_valid high for one cycle. Most of the path from request to result lies in
// the fifteen-stage series pipeline, ahead of the four output stages. One beat can
// enter every cycle, so throughput is one beat per clock. Beats leave in order.
// The receiver cannot stall the output; it must take every beat.
// csr_wr_en writes the overhead threshold from csr_wr_data at the next edge;
// change it only while no beat is in flight.
// A synchronous reset empties the pipeline, drops every beat in flight and
// loads the threshold with its reset value. No result comes out of reset.
module view_frame_from_bearing #(
   parameter int ANGLE_BITS = 16,
   parameter int COEF_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire vfb_pkg::req_type      req_data,
   output logic                       rsp_valid,
   output vfb_pkg::rsp_type           rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [vfb_pkg::THR_W-1:0] csr_wr_data
);
   import vfb_pkg::*;

   localparam int F    = COEF_BITS - 1;
   localparam int CW   = COEF_BITS + 1;
   localparam int SH1  = 30 - F;
   localparam int SHP1 = (SH1 > 0) ? SH1 : 0;
   localparam int SHN1 = (SH1 < 0) ? -SH1 : 0;
   localparam int SH2  = F - 15;
   localparam int SHP2 = (SH2 > 0) ? SH2 : 0;
   localparam int SHN2 = (SH2 < 0) ? -SH2 : 0;
   localparam int VW   = 40;
   localparam logic [THR_W-1:0] THR_RESET = 15'd32762;
   localparam logic signed [CW-1:0] ONE = CW'(1) <<< F;

   function automatic logic signed [CW-1:0] to_coef(input logic [30:0] v);
      logic [VW-1:0] w;
      begin
         w = ((VW'(v) + ((VW'(1) << SHP1) >> 1)) >> SHP1) << SHN1;
         return CW'(w);
      end
   endfunction

   function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
      begin
         return (v < 0) ? CW'(-v) : CW'(v);
      end
   endfunction

   function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
      logic          neg;
      logic [2*CW-1:0] p;
      begin
         neg = (a < 0) != (b < 0);
         p   = ((2*CW)'(mag(a)) * (2*CW)'(mag(b)) + ((2*CW)'(1) << (F - 1))) >> F;
         return neg ? -CW'(p) : CW'(p);
      end
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [CW:0] v);
      logic          neg;
      logic [VW-1:0] m;
      begin
         neg = v < 0;
         m   = neg ? VW'(-v) : VW'(v);
         m   = ((m + ((VW'(1) << SHP2) >> 1)) >> SHP2) << SHN2;
         if (neg) begin
            return (m > VW'(32768)) ? -16'sd32768 : 16'(-m);
         end
         return (m > VW'(32767)) ? 16'sd32767 : 16'(m);
      end
   endfunction

   logic [THR_W-1:0] thr_ff;

   logic [ANGLE_BITS-1:0] az_ang;
   logic [ANGLE_BITS-1:0] alt_ang;
   logic [31:0]           az_turn;
   logic [31:0]           alt_turn;

   logic        az_vld;
   logic [30:0] az_sin;
   logic [30:0] az_cos;
   logic [1:0]  az_quad;
   logic        az_op;
   logic        alt_vld;
   logic [30:0] alt_sin;
   logic [30:0] alt_cos;
   logic [1:0]  alt_quad;
   logic        alt_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   assign busy     = 1'b0;
   assign az_ang   = ANGLE_BITS'(req_data.azimuth);
   assign alt_ang  = ANGLE_BITS'(req_data.altitude);
   assign az_turn  = {az_ang, {(32 - ANGLE_BITS){1'b0}}};
   assign alt_turn = {alt_ang, {(32 - ANGLE_BITS){1'b0}}};

   vfb_sincos u_az (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start),
      .turn      (az_turn),
      .tag_in    (req_data.op),
      .valid_out (az_vld),
      .sin_q30   (az_sin),
      .cos_q30   (az_cos),
      .quad_out  (az_quad),
      .tag_out   (az_op)
   );

   vfb_sincos u_alt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start),
      .turn      (alt_turn),
      .tag_in    (1'b0),
      .valid_out (alt_vld),
      .sin_q30   (alt_sin),
      .cos_q30   (alt_cos),
      .quad_out  (alt_quad),
      .tag_out   (alt_tag)
   );

   // Stage 1: signed sine and cosine of both angles.
   logic                 v1_ff;
   logic                 op1_ff;
   logic signed [CW-1:0] sz1_ff, cz1_ff, sa1_ff, ca1_ff;
   logic signed [CW-1:0] sz_in, cz_in, sa_in, ca_in;
   logic signed [CW-1:0] s0z, c0z, s0a, c0a;

   always_comb begin
      s0z = to_coef(az_sin);
      c0z = to_coef(az_cos);
      s0a = to_coef(alt_sin);
      c0a = to_coef(alt_cos);
      unique case (az_quad)
         2'd0: begin sz_in = s0z;  cz_in = c0z;  end
         2'd1: begin sz_in = c0z;  cz_in = -s0z; end
         2'd2: begin sz_in = -s0z; cz_in = -c0z; end
         default: begin sz_in = -c0z; cz_in = s0z; end
      endcase
      unique case (alt_quad)
         2'd0: begin sa_in = s0a;  ca_in = c0a;  end
         2'd1: begin sa_in = c0a;  ca_in = -s0a; end
         2'd2: begin sa_in = -s0a; ca_in = -c0a; end
         default: begin sa_in = -c0a; ca_in = s0a; end
      endcase
   end

   // Stage 2: eye row, overhead test and right row.
   logic                 v2_ff, op2_ff, snap2_ff, pos2_ff;
   logic signed [CW-1:0] m00_2_ff, m01_2_ff, m20_2_ff, m21_2_ff, m22_2_ff;
   logic                 snap_in;
   logic signed [CW-1:0] m00_in, m01_in;

   always_comb begin
      snap_in = (64'(mag(sa1_ff)) << 15) > (64'(thr_ff) << F);
      if (ca1_ff > 0) begin
         m00_in = -cz1_ff;
         m01_in = sz1_ff;
      end else if (ca1_ff < 0) begin
         m00_in = cz1_ff;
         m01_in = -sz1_ff;
      end else begin
         m00_in = '0;
         m01_in = '0;
      end
   end

   // Stage 3: cross products for the up row.
   logic                 v3_ff, op3_ff, snap3_ff, pos3_ff;
   logic signed [CW-1:0] m00_3_ff, m01_3_ff, m20_3_ff, m21_3_ff, m22_3_ff;
   logic signed [CW-1:0] pa3_ff, pb3_ff, pc3_ff, pd3_ff;

   // Stage 4: assemble, round, transpose.
   logic               v4_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic signed [CW:0] mm [3][3];
   logic [15:0]        qq [3][3];

   always_comb begin
      if (snap3_ff) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mm[i][j] = '0;
            end
         end
         mm[0][0] = (CW+1)'(ONE);
         mm[1][1] = pos3_ff ? (CW+1)'(ONE) : -(CW+1)'(ONE);
         mm[2][2] = mm[1][1];
      end else begin
         mm[0][0] = (CW+1)'(m00_3_ff);
         mm[0][1] = (CW+1)'(m01_3_ff);
         mm[0][2] = '0;
         mm[1][0] = -(CW+1)'(pa3_ff);
         mm[1][1] = (CW+1)'(pb3_ff);
         mm[1][2] = (CW+1)'(pc3_ff) - (CW+1)'(pd3_ff);
         mm[2][0] = (CW+1)'(m20_3_ff);
         mm[2][1] = (CW+1)'(m21_3_ff);
         mm[2][2] = (CW+1)'(m22_3_ff);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            qq[i][j] = op3_ff ? to_q15(mm[j][i]) : to_q15(mm[i][j]);
         end
      end
      rsp_in.row0_col0 = qq[0][0];
      rsp_in.row0_col1 = qq[0][1];
      rsp_in.row0_col2 = qq[0][2];
      rsp_in.row1_col0 = qq[1][0];
      rsp_in.row1_col1 = qq[1][1];
      rsp_in.row1_col2 = qq[1][2];
      rsp_in.row2_col0 = qq[2][0];
      rsp_in.row2_col1 = qq[2][1];
      rsp_in.row2_col2 = qq[2][2];
      rsp_in.overhead  = snap3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= az_vld & alt_vld & ~alt_tag | az_vld & alt_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= az_op;
      sz1_ff   <= sz_in;
      cz1_ff   <= cz_in;
      sa1_ff   <= sa_in;
      ca1_ff   <= ca_in;

      op2_ff   <= op1_ff;
      snap2_ff <= snap_in;
      pos2_ff  <= sa1_ff > 0;
      m00_2_ff <= m00_in;
      m01_2_ff <= m01_in;
      m20_2_ff <= qmul(ca1_ff, sz1_ff);
      m21_2_ff <= qmul(ca1_ff, cz1_ff);
      m22_2_ff <= sa1_ff;

      op3_ff   <= op2_ff;
      snap3_ff <= snap2_ff;
      pos3_ff  <= pos2_ff;
      m00_3_ff <= m00_2_ff;
      m01_3_ff <= m01_2_ff;
      m20_3_ff <= m20_2_ff;
      m21_3_ff <= m21_2_ff;
      m22_3_ff <= m22_2_ff;
      pa3_ff   <= qmul(m22_2_ff, m01_2_ff);
      pb3_ff   <= qmul(m22_2_ff, m00_2_ff);
      pc3_ff   <= qmul(m20_2_ff, m01_2_ff);
      pd3_ff   <= qmul(m21_2_ff, m00_2_ff);

      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_overhead_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overhead |->
         rsp_data.row0_col0 == 16'sd32767 && rsp_data.row0_col1 == 16'sd0 &&
         rsp_data.row1_col0 == 16'sd0 && rsp_data.row2_col0 == 16'sd0)
      else $error("overhead beat without north-up frame");

   a_zero_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.row0_col2 == 16'sd0 || rsp_data.row2_col0 == 16'sd0)
      else $error("right row has a vertical component");
`endif

endmodule

`default_nettype wire
